/* design/assert_macros.svh */
// Assertion macros shared by the render state dirty cache modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/rdsc_pkg.sv */
// Types and constants shared by the render state dirty cache.
package rdsc_pkg;

    localparam int STATE_TYPES    = 32;
    localparam int TYPE_BITS      = 5;
    localparam int HANDLE_IN_BITS = 32;
    localparam int COUNT_BITS     = 6;
    localparam int CMD_BITS       = 3;
    localparam int KIND_BITS      = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_BIND      = 3'd0,
        CMD_RESET_ONE = 3'd1,
        CMD_RESET_ALL = 3'd2,
        CMD_FLUSH     = 3'd3,
        CMD_LOAD      = 3'd4
    } t_cmd;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_BIND_ACK      = 3'd0,
        KIND_RESET_ACK     = 3'd1,
        KIND_RESET_ALL_ACK = 3'd2,
        KIND_FLUSH_ENTRY   = 3'd3,
        KIND_FLUSH_EMPTY   = 3'd4,
        KIND_LOAD_ACK      = 3'd5
    } t_kind;

    // Source of the pair memory read address.
    typedef enum logic [1:0] {
        RD_TYPE,
        RD_WALK,
        RD_LIST
    } t_rd_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_LOAD,
        S_RALL,
        S_RALL_ACK,
        S_FL_RD,
        S_FL_OUT,
        S_FL_EMPTY
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic                 load_in;
        logic                 rd_en;
        t_rd_src              rd_src;
        logic [TYPE_BITS-1:0] walk_idx;
        logic                 cmp_en;
        logic                 use_default;
        logic                 load_wr;
        logic                 flush_clear;
        logic                 list_clear;
        logic                 emit;
        t_kind                kind;
        logic                 emit_last;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic                  out_free;
        logic [COUNT_BITS-1:0] list_cnt;
    } t_dp_sts;

endpackage

/* design/rdsc_if.sv */
// Input and result channel interfaces of the render state dirty cache.
interface rdsc_in_if;
    import rdsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_BITS-1:0]       cmd;
    logic [TYPE_BITS-1:0]      state_type;
    logic [HANDLE_IN_BITS-1:0] command_handle;
    logic [HANDLE_IN_BITS-1:0] data_handle;

    modport source (output valid, cmd, state_type, command_handle, data_handle,
                    input ready);
    modport sink   (input valid, cmd, state_type, command_handle, data_handle,
                    output ready);
endinterface

interface rdsc_out_if;
    import rdsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_BITS-1:0]      kind;
    logic                      changed;
    logic [COUNT_BITS-1:0]     count;
    logic [TYPE_BITS-1:0]      flushed_type;
    logic [HANDLE_IN_BITS-1:0] flushed_command;
    logic [HANDLE_IN_BITS-1:0] flushed_data;
    logic                      last;

    modport source (output valid, kind, changed, count, flushed_type, flushed_command,
                    flushed_data, last, input ready);
    modport sink   (input valid, kind, changed, count, flushed_type, flushed_command,
                    flushed_data, last, output ready);
endinterface

/* design/render_state_dirty_cache_top.sv */
// Top level of the render state dirty cache: controller, datapath and channel wiring.
//
// Usage: commands arrive on i_in (valid/ready transfer of cmd, state_type, command_handle,
// data_handle); result items leave on o_out (valid/ready transfer of kind, changed, count,
// flushed_type, flushed_command, flushed_data, last). One command is worked on at a time;
// i_in.ready is high only while the sequencer is idle.
// Steps from input transfer to result in the output register, receiver ready:
//   bind, reset one: latch, registered pair read, then compare and write.
//   load default: latch, then write. reset all: latch, then one type per cycle
//   through the pair memory read port, with the compare in the cycle after the read.
//   flush: list lookup plus pair read, then result, for each listed entry in turn;
//   an empty flush gives one result. Unknown command codes are taken and give no result.
// Throughput is set by the single read port of the pair memories and the one-entry
// result register: the next command is taken the cycle after the last result loads.
// Reset (i_rst_n low, synchronous) marks every type dirty and lists types 0 to 31 in
// order; pair memories are not cleared and must be loaded before they are read.
// Receiver stall: a finished result waits in the output register; the sequencer holds in
// its emit step, with no state written, until that register frees.
module render_state_dirty_cache_top #(
    parameter int HANDLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdsc_in_if.sink     i_in,
    rdsc_out_if.source  o_out
);
    import rdsc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    rdsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_in_cmd   (i_in.cmd),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    rdsc_dpath #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_state_type      (i_in.state_type),
        .i_command_handle  (i_in.command_handle),
        .i_data_handle     (i_in.data_handle),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_kind            (o_out.kind),
        .o_changed         (o_out.changed),
        .o_count           (o_out.count),
        .o_flushed_type    (o_out.flushed_type),
        .o_flushed_command (o_out.flushed_command),
        .o_flushed_data    (o_out.flushed_data),
        .o_last            (o_out.last)
    );

    assign i_in.ready = w_in_ready;

endmodule

/* design/rdsc_ctrl.sv */
// Command sequencer of the render state dirty cache.
`include "assert_macros.svh"

module rdsc_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rdsc_pkg::CMD_BITS-1:0] i_in_cmd,
    output rdsc_pkg::t_dp_cmd            o_cmd,
    input  rdsc_pkg::t_dp_sts            i_sts
);
    import rdsc_pkg::*;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_idx, n_idx;
    logic                  r_use_def, n_use_def;
    logic                  w_flush_last;

    assign w_flush_last = (r_idx + COUNT_BITS'(1)) == i_sts.list_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_use_def <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_use_def <= n_use_def;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_use_def  = r_use_def;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.walk_idx = r_idx[TYPE_BITS-1:0];

        unique case (r_state)
            S_IDLE: begin
                // no transfer while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_idx         = '0;
                    unique case (i_in_cmd)
                        CMD_BIND: begin
                            n_use_def = 1'b0;
                            n_state   = S_RD;
                        end
                        CMD_RESET_ONE: begin
                            n_use_def = 1'b1;
                            n_state   = S_RD;
                        end
                        CMD_RESET_ALL: n_state = S_RALL;
                        CMD_FLUSH: begin
                            n_state = (i_sts.list_cnt == '0) ? S_FL_EMPTY : S_FL_RD;
                        end
                        CMD_LOAD: n_state = S_LOAD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_TYPE;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (i_sts.out_free) begin
                    o_cmd.cmp_en      = 1'b1;
                    o_cmd.use_default = r_use_def;
                    o_cmd.emit        = 1'b1;
                    o_cmd.kind        = r_use_def ? KIND_RESET_ACK : KIND_BIND_ACK;
                    n_state           = S_IDLE;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_wr = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = KIND_LOAD_ACK;
                    n_state       = S_IDLE;
                end
            end
            S_RALL: begin
                // read type r_idx while comparing type r_idx-1
                o_cmd.rd_en       = (r_idx != COUNT_BITS'(STATE_TYPES));
                o_cmd.rd_src      = RD_WALK;
                o_cmd.cmp_en      = (r_idx != '0);
                o_cmd.use_default = 1'b1;
                n_idx             = r_idx + COUNT_BITS'(1);
                if (r_idx == COUNT_BITS'(STATE_TYPES)) begin
                    n_state = S_RALL_ACK;
                end
            end
            S_RALL_ACK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_RESET_ALL_ACK;
                    n_state    = S_IDLE;
                end
            end
            S_FL_RD: begin
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_src      = RD_LIST;
                o_cmd.flush_clear = 1'b1;
                n_state           = S_FL_OUT;
            end
            S_FL_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = KIND_FLUSH_ENTRY;
                    o_cmd.emit_last = w_flush_last;
                    if (w_flush_last) begin
                        o_cmd.list_clear = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_idx   = r_idx + COUNT_BITS'(1);
                        n_state = S_FL_RD;
                    end
                end
            end
            S_FL_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_FLUSH_EMPTY;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_IMP(a_emit_needs_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free)
    `ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, r_state == S_RALL, r_idx <= COUNT_BITS'(STATE_TYPES))
    `ASSERT_IMP(a_no_wr_clash, i_clk, i_rst_n, o_cmd.load_wr, !o_cmd.cmp_en)
    `ASSERT_NXT(a_flush_done, i_clk, i_rst_n, o_cmd.list_clear, r_state == S_IDLE)

endmodule

/* design/rdsc_dpath.sv */
// Pair memories, dirty tracking and result register of the render state dirty cache.
`include "assert_macros.svh"

module rdsc_dpath #(
    parameter int HANDLE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rdsc_pkg::t_dp_cmd                  i_cmd,
    output rdsc_pkg::t_dp_sts                  o_sts,
    input  logic [rdsc_pkg::TYPE_BITS-1:0]      i_state_type,
    input  logic [rdsc_pkg::HANDLE_IN_BITS-1:0] i_command_handle,
    input  logic [rdsc_pkg::HANDLE_IN_BITS-1:0] i_data_handle,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [rdsc_pkg::KIND_BITS-1:0]      o_kind,
    output logic                               o_changed,
    output logic [rdsc_pkg::COUNT_BITS-1:0]     o_count,
    output logic [rdsc_pkg::TYPE_BITS-1:0]      o_flushed_type,
    output logic [rdsc_pkg::HANDLE_IN_BITS-1:0] o_flushed_command,
    output logic [rdsc_pkg::HANDLE_IN_BITS-1:0] o_flushed_data,
    output logic                               o_last
);
    import rdsc_pkg::*;

    localparam int PairBits = 2 * HANDLE_BITS;
    localparam int CopyBits = (HANDLE_BITS < HANDLE_IN_BITS) ? HANDLE_BITS : HANDLE_IN_BITS;

    // latched command payload
    logic [TYPE_BITS-1:0]      r_type;
    logic [HANDLE_IN_BITS-1:0] r_in_cmd;
    logic [HANDLE_IN_BITS-1:0] r_in_dat;

    // pair memories, registered read
    logic [PairBits-1:0]  r_cur_mem [STATE_TYPES];
    logic [PairBits-1:0]  r_def_mem [STATE_TYPES];
    logic [PairBits-1:0]  r_cur_rd;
    logic [PairBits-1:0]  r_def_rd;
    logic [TYPE_BITS-1:0] r_rd_type;

    // dirty tracking
    logic [STATE_TYPES-1:0] r_dirty;
    logic [TYPE_BITS-1:0]   r_list [STATE_TYPES];
    logic [COUNT_BITS-1:0]  r_list_cnt;
    logic [COUNT_BITS-1:0]  r_chg_cnt;

    // result register
    logic                      r_out_valid;
    logic [KIND_BITS-1:0]      r_o_kind;
    logic                      r_o_changed;
    logic [COUNT_BITS-1:0]     r_o_count;
    logic [TYPE_BITS-1:0]      r_o_type;
    logic [HANDLE_IN_BITS-1:0] r_o_cmd;
    logic [HANDLE_IN_BITS-1:0] r_o_dat;
    logic                      r_o_last;
    logic                      n_o_changed;
    logic [COUNT_BITS-1:0]     n_o_count;
    logic [TYPE_BITS-1:0]      n_o_type;
    logic [HANDLE_IN_BITS-1:0] n_o_cmd;
    logic [HANDLE_IN_BITS-1:0] n_o_dat;
    logic                      n_o_last;

    logic [HANDLE_BITS-1:0]    w_in_cmd_h;
    logic [HANDLE_BITS-1:0]    w_in_dat_h;
    logic [PairBits-1:0]       w_in_pair;
    logic [PairBits-1:0]       w_new_pair;
    logic                      w_diff;
    logic                      w_chg;
    logic                      w_append;
    logic [TYPE_BITS-1:0]      w_list_type;
    logic [TYPE_BITS-1:0]      w_rd_addr;
    logic                      w_cur_we;
    logic [TYPE_BITS-1:0]      w_wr_addr;
    logic [PairBits-1:0]       w_wr_data;
    logic [HANDLE_IN_BITS-1:0] w_fl_cmd;
    logic [HANDLE_IN_BITS-1:0] w_fl_dat;

    // handles masked or zero-extended to the stored width
    always_comb begin
        w_in_cmd_h = '0;
        w_in_dat_h = '0;
        w_in_cmd_h[CopyBits-1:0] = r_in_cmd[CopyBits-1:0];
        w_in_dat_h[CopyBits-1:0] = r_in_dat[CopyBits-1:0];
        w_fl_cmd = '0;
        w_fl_dat = '0;
        w_fl_cmd[CopyBits-1:0] = r_cur_rd[HANDLE_BITS +: CopyBits];
        w_fl_dat[CopyBits-1:0] = r_cur_rd[CopyBits-1:0];
    end

    assign w_in_pair   = {w_in_cmd_h, w_in_dat_h};
    assign w_new_pair  = i_cmd.use_default ? r_def_rd : w_in_pair;
    assign w_diff      = (w_new_pair != r_cur_rd);
    assign w_chg       = i_cmd.cmp_en && w_diff;
    assign w_append    = w_chg && !r_dirty[r_rd_type];
    assign w_list_type = r_list[i_cmd.walk_idx];

    always_comb begin
        case (i_cmd.rd_src)
            RD_WALK: w_rd_addr = i_cmd.walk_idx;
            RD_LIST: w_rd_addr = w_list_type;
            default: w_rd_addr = r_type;
        endcase
    end

    assign w_cur_we  = w_chg || i_cmd.load_wr;
    assign w_wr_addr = i_cmd.load_wr ? r_type : r_rd_type;
    assign w_wr_data = i_cmd.load_wr ? w_in_pair : w_new_pair;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_type   <= i_state_type;
            r_in_cmd <= i_command_handle;
            r_in_dat <= i_data_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cur_we) begin
            r_cur_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_cur_rd <= r_cur_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_def_mem[r_type] <= w_in_pair;
        end
        if (i_cmd.rd_en) begin
            r_def_rd  <= r_def_mem[w_rd_addr];
            r_rd_type <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty    <= '1;
            r_list_cnt <= COUNT_BITS'(STATE_TYPES);
            r_chg_cnt  <= '0;
            for (int i = 0; i < STATE_TYPES; i++) begin
                r_list[i] <= TYPE_BITS'(i);
            end
        end else begin
            if (i_cmd.load_in) begin
                r_chg_cnt <= '0;
            end else if (w_chg) begin
                r_chg_cnt <= r_chg_cnt + COUNT_BITS'(1);
            end
            if (w_append) begin
                r_dirty[r_rd_type]                  <= 1'b1;
                r_list[r_list_cnt[TYPE_BITS-1:0]]   <= r_rd_type;
                r_list_cnt                          <= r_list_cnt + COUNT_BITS'(1);
            end
            if (i_cmd.flush_clear) begin
                r_dirty[w_list_type] <= 1'b0;
            end
            if (i_cmd.list_clear) begin
                r_list_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // fields that do not apply to a result kind stay zero, except last, which is one
    always_comb begin
        n_o_changed = 1'b0;
        n_o_count   = '0;
        n_o_type    = '0;
        n_o_cmd     = '0;
        n_o_dat     = '0;
        n_o_last    = 1'b1;
        case (i_cmd.kind) inside
            KIND_BIND_ACK, KIND_RESET_ACK: n_o_changed = w_diff;
            KIND_RESET_ALL_ACK: n_o_count = r_chg_cnt;
            KIND_FLUSH_ENTRY: begin
                n_o_count = r_list_cnt;
                n_o_type  = r_rd_type;
                n_o_cmd   = w_fl_cmd;
                n_o_dat   = w_fl_dat;
                n_o_last  = i_cmd.emit_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind    <= i_cmd.kind;
            r_o_changed <= n_o_changed;
            r_o_count   <= n_o_count;
            r_o_type    <= n_o_type;
            r_o_cmd     <= n_o_cmd;
            r_o_dat     <= n_o_dat;
            r_o_last    <= n_o_last;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.list_cnt  = r_list_cnt;

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_o_kind;
    assign o_changed         = r_o_changed;
    assign o_count           = r_o_count;
    assign o_flushed_type    = r_o_type;
    assign o_flushed_command = r_o_cmd;
    assign o_flushed_data    = r_o_dat;
    assign o_last            = r_o_last;

    `ASSERT_IMP(a_append_room, i_clk, i_rst_n, w_append, r_list_cnt < COUNT_BITS'(STATE_TYPES))
    `ASSERT_NXT(a_clear_empties, i_clk, i_rst_n, i_cmd.list_clear, r_list_cnt == '0)
    `ASSERT_NXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, r_out_valid)

endmodule
